// File: hdl/fedm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fedm_pkg
// shared types, constants and arithmetic helpers of the feedback echo mixer
// ---------------------------------------------------------------------------
package fedm_pkg;

	localparam int STORE_DEPTH = 16384;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int SAMPLE_W    = 12;
	localparam int DLY_W       = 15;
	localparam int GAIN_W      = 11;
	localparam int CFG_W       = 15;
	localparam int CFG_IDX_W   = 2;
	localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
	localparam int QUOT_W      = SAMPLE_W + 2;
	localparam int MIX_W       = SAMPLE_W + 3;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WET_LEVEL     = 2'd2;

	localparam logic [DLY_W-1:0]  DELAY_LENGTH_RST  = 15'd10000;
	localparam logic [GAIN_W-1:0] FEEDBACK_GAIN_RST = 11'd256;
	localparam logic [GAIN_W-1:0] WET_LEVEL_RST     = 11'd512;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_left;
		logic signed [SAMPLE_W-1:0] sample_right;
	} sample_beat_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] dac_left;
		logic [SAMPLE_W-1:0] dac_right;
	} dac_beat_t;

	typedef struct packed {
		logic [DLY_W-1:0]  delay_length;
		logic [GAIN_W-1:0] feedback_gain;
		logic [GAIN_W-1:0] wet_level;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] rd_addr;
		logic [ADDR_W-1:0] wr_addr;
		logic              present;
	} rd_req_t;

	// signed product divided by 1024, truncating toward zero
	function automatic logic signed [QUOT_W-1:0] div1024(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + (p[PROD_W-1] ? PROD_W'(1023) : PROD_W'(0));
		return QUOT_W'(t >>> 10);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat12(input logic signed [QUOT_W-1:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > QUOT_W'(2047)) begin
			r = 12'sd2047;
		end else if (v < -QUOT_W'(2048)) begin
			r = -12'sd2048;
		end else begin
			r = SAMPLE_W'(v);
		end
		return r;
	endfunction

	function automatic logic [SAMPLE_W-1:0] to_dac(input logic signed [SAMPLE_W-1:0] dry,
	                                               input logic signed [QUOT_W-1:0] wet);
		logic signed [MIX_W-1:0] v;
		logic [SAMPLE_W-1:0]     r;
		v = MIX_W'(dry) + MIX_W'(wet) + MIX_W'(2048);
		if (v < 0) begin
			r = '0;
		end else if (v > MIX_W'(4095)) begin
			r = 12'd4095;
		end else begin
			r = SAMPLE_W'(v);
		end
		return r;
	endfunction

endpackage

// File: hdl/fedm_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fedm_ram
// generic simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module fedm_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/fedm_cfg_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fedm_cfg_regs
// configuration registers: delay length, feedback gain, wet level
// ---------------------------------------------------------------------------
module fedm_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fedm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fedm_pkg::CFG_W-1:0]     cfg_data,
	output fedm_pkg::cfg_t                 cfg
);
	import fedm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_length  <= DELAY_LENGTH_RST;
			cfg_q.feedback_gain <= FEEDBACK_GAIN_RST;
			cfg_q.wet_level     <= WET_LEVEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELAY_LENGTH:  cfg_q.delay_length  <= cfg_data[DLY_W-1:0];
				REG_FEEDBACK_GAIN: cfg_q.feedback_gain <= cfg_data[GAIN_W-1:0];
				REG_WET_LEVEL:     cfg_q.wet_level     <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/fedm_addr_gen.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fedm_addr_gen
// write pointer, wrap tracking and delayed read address of the echo store
// ---------------------------------------------------------------------------
module fedm_addr_gen (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [fedm_pkg::DLY_W-1:0] delay_length,
	output fedm_pkg::rd_req_t          req
);
	import fedm_pkg::*;

	localparam int DCMP_W = (DLY_W > ADDR_W + 1) ? DLY_W : ADDR_W + 1;

	logic [ADDR_W-1:0] wp_q;
	logic              wrapped_q;
	logic [DCMP_W-1:0] d_ext;
	logic [ADDR_W:0]   d_eff;
	logic [ADDR_W:0]   wp_ext;
	logic [ADDR_W:0]   rd_full;

	always_comb begin
		d_ext  = DCMP_W'(delay_length);
		wp_ext = {1'b0, wp_q};
		if (d_ext == '0) begin
			d_eff = (ADDR_W + 1)'(1);
		end else if (d_ext > DCMP_W'(STORE_DEPTH)) begin
			d_eff = (ADDR_W + 1)'(STORE_DEPTH);
		end else begin
			d_eff = d_ext[ADDR_W:0];
		end
		if (wp_ext >= d_eff) begin
			rd_full = wp_ext - d_eff;
		end else begin
			rd_full = wp_ext + (ADDR_W + 1)'(STORE_DEPTH) - d_eff;
		end
	end

	// entries not yet written since reset read as zero
	assign req.rd_addr = rd_full[ADDR_W-1:0];
	assign req.wr_addr = wp_q;
	assign req.present = wrapped_q || (rd_full[ADDR_W-1:0] < wp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
		end else if (accept) begin
			if (wp_q == ADDR_W'(STORE_DEPTH - 1)) begin
				wp_q      <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wp_q <= wp_q + 1'b1;
			end
		end
	end

endmodule

// File: hdl/feedback_echo_delay_mixer_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// feedback_echo_delay_mixer_top
// stereo echo: mono feedback delay store fed from left, mixed into both outputs
// path: a taken sample beat moves through stage s1, stage s2 and the output register
// throughput: one beat per cycle unless stalled, set by one ram read and write
// reset: registers return to their defaults, write pointer to zero; store
// entries not written since reset read as zero, no clearing pass
// ---------------------------------------------------------------------------
module feedback_echo_delay_mixer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  fedm_pkg::sample_beat_t         sample_beat,
	output logic                           dac_valid,
	input  logic                           dac_stall,
	output fedm_pkg::dac_beat_t            dac_beat,
	input  logic                           cfg_we,
	input  logic [fedm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fedm_pkg::CFG_W-1:0]     cfg_data
);
	import fedm_pkg::*;

	cfg_t    cfg;
	rd_req_t req;

	logic advance;
	logic accept;

	logic                       v_s1;
	logic signed [SAMPLE_W-1:0] left_s1;
	logic signed [SAMPLE_W-1:0] right_s1;
	logic [ADDR_W-1:0]          rd_s1;
	logic [ADDR_W-1:0]          wp_s1;
	logic                       present_s1;

	logic                       v_s2;
	logic signed [SAMPLE_W-1:0] left_s2;
	logic signed [SAMPLE_W-1:0] right_s2;
	logic [ADDR_W-1:0]          wp_s2;
	logic signed [PROD_W-1:0]   pfb_s2;
	logic signed [PROD_W-1:0]   pwet_s2;

	logic                       lw_v_q;
	logic [ADDR_W-1:0]          lw_addr_q;
	logic signed [SAMPLE_W-1:0] lw_data_q;

	logic                       out_v_q;
	dac_beat_t                  out_q;

	logic [SAMPLE_W-1:0]        ram_rdata;
	logic signed [SAMPLE_W-1:0] delayed;
	logic signed [PROD_W-1:0]   pfb;
	logic signed [PROD_W-1:0]   pwet;
	logic signed [SAMPLE_W-1:0] fb;
	logic signed [QUOT_W-1:0]   wet;

	assign advance      = !(out_v_q && dac_stall);
	assign sample_stall = !advance;
	assign accept       = sample_valid && advance;

	fedm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fedm_addr_gen u_addr (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.delay_length (cfg.delay_length),
		.req          (req)
	);

	fedm_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (advance && v_s2),
		.waddr (wp_s2),
		.wdata (fb),
		.re    (advance),
		.raddr (req.rd_addr),
		.rdata (ram_rdata)
	);

	// newest pending write wins over older ones and over the ram
	always_comb begin
		priority if (v_s2 && (wp_s2 == rd_s1)) begin
			delayed = fb;
		end else if (lw_v_q && (lw_addr_q == rd_s1)) begin
			delayed = lw_data_q;
		end else if (present_s1) begin
			delayed = signed'(ram_rdata);
		end else begin
			delayed = '0;
		end
		pfb  = PROD_W'(delayed) * PROD_W'(signed'({1'b0, cfg.feedback_gain}));
		pwet = PROD_W'(delayed) * PROD_W'(signed'({1'b0, cfg.wet_level}));
	end

	always_comb begin
		fb  = sat12(QUOT_W'(left_s2) + div1024(pfb_s2));
		wet = div1024(pwet_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			lw_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else if (advance) begin
			v_s1    <= accept;
			v_s2    <= v_s1;
			lw_v_q  <= v_s2;
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			left_s1    <= sample_beat.sample_left;
			right_s1   <= sample_beat.sample_right;
			rd_s1      <= req.rd_addr;
			wp_s1      <= req.wr_addr;
			present_s1 <= req.present;

			left_s2    <= left_s1;
			right_s2   <= right_s1;
			wp_s2      <= wp_s1;
			pfb_s2     <= pfb;
			pwet_s2    <= pwet;

			lw_addr_q  <= wp_s2;
			lw_data_q  <= fb;

			out_q.dac_left  <= to_dac(left_s2, wet);
			out_q.dac_right <= to_dac(right_s2, wet);
		end
	end

	assign dac_valid = out_v_q;
	assign dac_beat  = out_q;

endmodule
